@@ design/qre_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qre_pkg
// Shared types and constants of the quicksort record engine.
// ----------------------------------------------------------------------------
package qre_pkg;

  localparam int unsigned DefDepth = 64;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned TagW     = 16;
  localparam int unsigned RecW     = KeyW + TagW;
  localparam int unsigned AddrW    = 3;

  // register indexes
  localparam logic RegSortOrder = 1'b0;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic        [TagW-1:0] tag;
  } rec_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic start_push;
    logic pop_rd;
    logic pop_take;
    logic piv_take;
    logic j_rd;
    logic j_take;
    logic j_skip;
    logic st_rd;
    logic fin_prep;
    logic sw_a;
    logic sw_b;
    logic adv;
    logic push_r;
    logic push_l;
    logic emit_rd;
    logic emit_take;
    logic emit_next;
    logic clr;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_single;
    logic ahead;
    logic j_at_hi;
    logic sp_zero;
    logic push_r_ok;
    logic push_l_ok;
    logic emit_last;
  } sts_t;

endpackage

@@ design/qre_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qre_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module qre_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/qre_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qre_ctrl
// Sequencer for load, partition sort and emission.
// ----------------------------------------------------------------------------
module qre_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          is_last_i,
  input  logic          out_stall_i,
  input  qre_pkg::sts_t sts_i,
  output qre_pkg::cmd_t cmd_o,
  output logic          in_stall_o
);
  import qre_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StStart, StPop, StPopW, StPiv, StJRd, StJCmp,
    StSwA, StSwB, StPushR, StPushL, StEmitRd, StEmitW, StEmitHold
  } state_e;

  state_e state_q, state_d;
  logic   fin_q, fin_d;

  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (is_last_i) state_d = StStart;
        end
      end
      StStart: begin
        if (sts_i.is_single) begin
          state_d = StEmitRd;
        end else begin
          cmd_o.start_push = 1'b1;
          state_d          = StPop;
        end
      end
      StPop: begin
        if (sts_i.sp_zero) begin
          state_d = StEmitRd;
        end else begin
          cmd_o.pop_rd = 1'b1;
          state_d      = StPopW;
        end
      end
      StPopW: begin
        cmd_o.pop_take = 1'b1;
        state_d        = StPiv;
      end
      StPiv: begin
        cmd_o.piv_take = 1'b1;
        state_d        = StJRd;
      end
      StJRd: begin
        if (sts_i.j_at_hi) begin
          // final swap puts the pivot in place
          cmd_o.fin_prep = 1'b1;
          cmd_o.st_rd    = 1'b1;
          fin_d          = 1'b1;
          state_d        = StSwA;
        end else begin
          cmd_o.j_rd = 1'b1;
          state_d    = StJCmp;
        end
      end
      StJCmp: begin
        cmd_o.j_take = 1'b1;
        fin_d        = 1'b0;
        if (sts_i.ahead) begin
          cmd_o.st_rd = 1'b1;
          state_d     = StSwA;
        end else begin
          cmd_o.j_skip = 1'b1;
          state_d      = StJRd;
        end
      end
      StSwA: begin
        cmd_o.sw_a = 1'b1;
        state_d    = StSwB;
      end
      StSwB: begin
        cmd_o.sw_b = 1'b1;
        if (fin_q) begin
          state_d = StPushR;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = StJRd;
        end
      end
      StPushR: begin
        cmd_o.push_r = sts_i.push_r_ok;
        state_d      = StPushL;
      end
      StPushL: begin
        cmd_o.push_l = sts_i.push_l_ok;
        state_d      = StPop;
      end
      StEmitRd: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = StEmitW;
      end
      StEmitW: begin
        cmd_o.emit_take = 1'b1;
        state_d         = StEmitHold;
      end
      StEmitHold: begin
        if (!out_stall_i) begin
          cmd_o.emit_next = 1'b1;
          if (sts_i.emit_last) begin
            cmd_o.clr = 1'b1;
            state_d   = StIdle;
          end else begin
            state_d = StEmitRd;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

@@ design/qre_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qre_dpath
// Record store, range stack, index registers and output word.
// ----------------------------------------------------------------------------
module qre_dpath #(
  parameter int unsigned Depth = qre_pkg::DefDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  qre_pkg::cmd_t                     cmd_i,
  output qre_pkg::sts_t                     sts_o,
  input  logic                              sort_order_i,
  input  logic signed [qre_pkg::KeyW-1:0]   sort_key_i,
  input  logic        [qre_pkg::TagW-1:0]   record_tag_i,
  output logic                              out_valid_o,
  output logic signed [qre_pkg::KeyW-1:0]   sorted_key_o,
  output logic        [qre_pkg::TagW-1:0]   sorted_tag_o,
  output logic                              end_of_run_o,
  output logic                              overflow_o
);
  import qre_pkg::*;

  localparam int unsigned IW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = IW + 1;
  localparam int unsigned SW = 2 * IW;

  logic [CW-1:0] count_q, sp_q;
  logic          dropped_q, out_valid_q;
  logic [IW-1:0] lo_q, hi_q, st_q, j_q, k_q;
  rec_t          pivot_q, cur_q, old_q, out_q;
  logic          eor_q, ovf_q;

  logic          full;
  logic          rec_we;
  logic [IW-1:0] rec_waddr, rec_raddr;
  rec_t          rec_wdata, rec_rdata;
  logic          stk_we;
  logic [SW-1:0] stk_wdata, stk_rdata;
  logic [IW-1:0] stk_lo, stk_hi;

  assign full   = (count_q == CW'(Depth));
  assign stk_lo = stk_rdata[SW-1:IW];
  assign stk_hi = stk_rdata[IW-1:0];

  // record store ports
  always_comb begin
    rec_we    = 1'b0;
    rec_waddr = count_q[IW-1:0];
    rec_wdata = '{key: sort_key_i, tag: record_tag_i};
    if (cmd_i.load && !full) begin
      rec_we = 1'b1;
    end else if (cmd_i.sw_a) begin
      rec_we    = 1'b1;
      rec_waddr = st_q;
      rec_wdata = cur_q;
    end else if (cmd_i.sw_b) begin
      rec_we    = 1'b1;
      rec_waddr = j_q;
      rec_wdata = old_q;
    end
    priority if (cmd_i.pop_take) rec_raddr = stk_hi;
    else if (cmd_i.st_rd)        rec_raddr = st_q;
    else if (cmd_i.emit_rd)      rec_raddr = k_q;
    else                         rec_raddr = j_q;
  end

  // range stack ports
  always_comb begin
    stk_we    = cmd_i.start_push | cmd_i.push_r | cmd_i.push_l;
    stk_wdata = {st_q + IW'(1), hi_q};
    priority if (cmd_i.start_push) stk_wdata = {IW'(0), IW'(count_q - CW'(1))};
    else if (cmd_i.push_l)         stk_wdata = {lo_q, st_q - IW'(1)};
    else                           stk_wdata = {st_q + IW'(1), hi_q};
  end

  qre_ram #(.Width(RecW), .Depth(Depth)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i (rec_wdata),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  qre_ram #(.Width(SW), .Depth(Depth)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (sp_q[IW-1:0]),
    .wdata_i (stk_wdata),
    .raddr_i (IW'(sp_q - CW'(1))),
    .rdata_o (stk_rdata)
  );

  // status
  always_comb begin
    sts_o.is_single = (count_q < CW'(2));
    sts_o.ahead     = sort_order_i ? (rec_rdata.key > pivot_q.key)
                                   : (rec_rdata.key < pivot_q.key);
    sts_o.j_at_hi   = (j_q == hi_q);
    sts_o.sp_zero   = (sp_q == '0);
    sts_o.push_r_ok = (({1'b0, st_q} + CW'(1)) < {1'b0, hi_q}) && (sp_q < CW'(Depth));
    sts_o.push_l_ok = ({1'b0, st_q} > ({1'b0, lo_q} + CW'(1))) && (sp_q < CW'(Depth));
    sts_o.emit_last = (({1'b0, k_q} + CW'(1)) == count_q);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dropped_q   <= 1'b0;
      sp_q        <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (full) dropped_q <= 1'b1;
        else      count_q   <= count_q + CW'(1);
      end
      if (cmd_i.start_push || cmd_i.push_r || cmd_i.push_l) sp_q <= sp_q + CW'(1);
      else if (cmd_i.pop_rd)                                 sp_q <= sp_q - CW'(1);
      if (cmd_i.emit_take) out_valid_q <= 1'b1;
      else if (cmd_i.emit_next) out_valid_q <= 1'b0;
      if (cmd_i.clr) begin
        count_q   <= '0;
        dropped_q <= 1'b0;
        k_q       <= '0;
      end else if (cmd_i.emit_next) begin
        k_q <= k_q + IW'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.pop_take) begin
      lo_q <= stk_lo;
      hi_q <= stk_hi;
      st_q <= stk_lo;
      j_q  <= stk_lo;
    end
    if (cmd_i.piv_take) pivot_q <= rec_rdata;
    if (cmd_i.fin_prep)    cur_q <= pivot_q;
    else if (cmd_i.j_take) cur_q <= rec_rdata;
    if (cmd_i.sw_a) old_q <= rec_rdata;
    if (cmd_i.j_skip) j_q <= j_q + IW'(1);
    if (cmd_i.adv) begin
      st_q <= st_q + IW'(1);
      j_q  <= j_q + IW'(1);
    end
    if (cmd_i.emit_take) begin
      out_q <= rec_rdata;
      eor_q <= sts_o.emit_last;
      ovf_q <= dropped_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sorted_key_o = out_q.key;
  assign sorted_tag_o = out_q.tag;
  assign end_of_run_o = eor_q;
  assign overflow_o   = ovf_q;

endmodule

@@ design/quicksort_record_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quicksort_record_engine
// Collects records, sorts them by Lomuto quicksort and emits them in order.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  input   | in        | in_valid_i / in_stall_o | sort_key_i, record_tag_i, is_last_i
//  output  | out       | out_valid_o/out_stall_i | sorted_key_o, sorted_tag_o,
//          |           |                         | end_of_run_o, overflow_o
//  config  | in        | APB psel/penable        | sort_order at address 0
//
// Loading takes one word per cycle. The word marked last starts the sort;
// each range is partitioned element by element, every read bound by the
// single read port of the record RAM. Emission reads, registers and holds
// each word and moves to the next only when the output is not stalled.
// Reset clears counts, flags, stack pointer and sort_order; the RAMs are not
// cleared. The input is stalled from the last word until the run is emitted.
// ----------------------------------------------------------------------------
module quicksort_record_engine #(
  parameter int unsigned DEPTH = qre_pkg::DefDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [qre_pkg::KeyW-1:0]   sort_key_i,
  input  logic        [qre_pkg::TagW-1:0]   record_tag_i,
  input  logic                              is_last_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [qre_pkg::KeyW-1:0]   sorted_key_o,
  output logic        [qre_pkg::TagW-1:0]   sorted_tag_o,
  output logic                              end_of_run_o,
  output logic                              overflow_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [qre_pkg::AddrW-1:0]         paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import qre_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic sort_order_q;

  // register index is the word address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sort_order_q <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == RegSortOrder)) begin
      sort_order_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegSortOrder) ? {31'd0, sort_order_q} : 32'd0;

  qre_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .is_last_i   (is_last_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o)
  );

  qre_dpath #(.Depth(DEPTH)) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .sort_order_i (sort_order_q),
    .sort_key_i   (sort_key_i),
    .record_tag_i (record_tag_i),
    .out_valid_o  (out_valid_o),
    .sorted_key_o (sorted_key_o),
    .sorted_tag_o (sorted_tag_o),
    .end_of_run_o (end_of_run_o),
    .overflow_o   (overflow_o)
  );

endmodule

@@ sim/quicksort_record_engine_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quicksort_record_engine_tb
// Self-checking bench for the quicksort record engine.
// ----------------------------------------------------------------------------
// Record sets are streamed in, closed by a word marked last, and the sorted
// words coming back are checked against a behavioural Lomuto quicksort kept
// in the bench. Directed sets cover key extremes, duplicates, single-word sets,
// both sort orders and overflow past DEPTH; random sets follow, with random
// idling on both sides and one long output hold-off that backs the engine up.
// ----------------------------------------------------------------------------
module quicksort_record_engine_tb;
  import qre_pkg::*;

  localparam int unsigned Depth    = DefDepth;
  localparam int unsigned MaxCyc   = 600000;
  localparam int unsigned DrainCyc = 64;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic        [TagW-1:0] tag;
    logic                   eor;
    logic                   ovf;
  } sorted_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [KeyW-1:0] sort_key_i = '0;
  logic [TagW-1:0] record_tag_i = '0;
  logic is_last_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [KeyW-1:0] sorted_key_o;
  logic [TagW-1:0] sorted_tag_o;
  logic end_of_run_o;
  logic overflow_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #1 clk_i = ~clk_i;

  quicksort_record_engine DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .sort_key_i(sort_key_i), .record_tag_i(record_tag_i), .is_last_i(is_last_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .sorted_key_o(sorted_key_o), .sorted_tag_o(sorted_tag_o),
    .end_of_run_o(end_of_run_o), .overflow_o(overflow_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Bench copy of engine state
  logic signed [KeyW-1:0] held_keys[Depth];
  logic [TagW-1:0] held_tags[Depth];
  int unsigned held_count = 0;
  bit held_dropped = 1'b0;
  bit descending = 1'b0;
  sorted_word_t expected_words[$];

  int unsigned mismatches = 0;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned runs_closed = 0;
  bit quiet_phase = 1'b0;   // no idling near the end
  bit hold_out = 1'b0;      // long hold-off request, cleared by the stall process

  // True when key a goes ahead of pivot b in the current order
  function automatic bit ahead_of(logic signed [KeyW-1:0] a, logic signed [KeyW-1:0] b);
    return descending ? (a > b) : (a < b);
  endfunction

  function automatic void swap_held(int unsigned i, int unsigned j);
    logic signed [KeyW-1:0] k;
    logic [TagW-1:0] t;
    k = held_keys[i]; t = held_tags[i];
    held_keys[i] = held_keys[j]; held_tags[i] = held_tags[j];
    held_keys[j] = k; held_tags[j] = t;
  endfunction

  // Lomuto quicksort on held records, explicit range stack, left range first
  function automatic void sort_held(int unsigned n);
    int unsigned lo_q[$];
    int unsigned hi_q[$];
    int unsigned lo, hi, st, p;
    logic signed [KeyW-1:0] pivot;
    if (n < 2) return;
    lo_q.push_back(0); hi_q.push_back(n - 1);
    while (lo_q.size() > 0) begin
      lo = lo_q.pop_back(); hi = hi_q.pop_back();
      pivot = held_keys[hi];
      st = lo;
      for (int unsigned j = lo; j < hi; j++) begin
        if (ahead_of(held_keys[j], pivot)) begin
          swap_held(st, j);
          st++;
        end
      end
      swap_held(st, hi);
      p = st;
      if (p + 1 < hi) begin lo_q.push_back(p + 1); hi_q.push_back(hi); end
      if (p > lo + 1) begin lo_q.push_back(lo); hi_q.push_back(p - 1); end
    end
  endfunction

  // Update bench state for one accepted word and queue any sorted words
  function automatic void predict_word(logic signed [KeyW-1:0] key, logic [TagW-1:0] tag,
                                       bit last);
    sorted_word_t w;
    if (held_count < Depth) begin
      held_keys[held_count] = key;
      held_tags[held_count] = tag;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (!last) return;
    sort_held(held_count);
    for (int unsigned k = 0; k < held_count; k++) begin
      w.key = held_keys[k];
      w.tag = held_tags[k];
      w.eor = (k + 1 == held_count);
      w.ovf = held_dropped;
      expected_words.push_back(w);
    end
    held_count = 0;
    held_dropped = 1'b0;
    runs_closed++;
  endfunction

  // Send one word, with an optional random gap ahead of it.
  // Valid is left high on return; wait_drained drops it.
  task automatic send_word(logic signed [KeyW-1:0] key, logic [TagW-1:0] tag, bit last);
    int unsigned gap;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sort_key_i <= key;
    record_tag_i <= tag;
    is_last_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_word(key, tag, last);
    words_in++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (DrainCyc) @(negedge clk_i);
  endtask

  // APB write of sort_order, followed by a read-back
  task automatic write_order(bit desc);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {RegSortOrder, 2'b00}; pwdata <= {$urandom_range(0, 1) ? 31'h7fff_ffff : 31'h0, desc};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    descending = desc;
    @(negedge clk_i);
    pwrite <= 1'b0; penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[0] !== desc) begin
      mismatches++;
      if (mismatches <= 10) $display("sort_order read-back: expected %0d got %0d", desc, prdata[0]);
    end
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic send_run(int unsigned n, int signed key_lo, int signed key_hi);
    for (int unsigned i = 0; i < n; i++)
      send_word($signed(key_lo + $urandom_range(0, key_hi - key_lo)), $urandom_range(0, 65535),
                i + 1 == n);
  endtask

  // Key extremes, a single word, duplicates and both orders
  task automatic test_directed();
    write_order(1'b0);
    send_word(32'sh7fff_ffff, 16'hffff, 1'b0);
    send_word(-32'sh8000_0000, 16'h0000, 1'b0);
    send_word(32'sh0, 16'h5555, 1'b0);
    send_word(-32'sd1, 16'haaaa, 1'b0);
    send_word(32'sh0, 16'h1234, 1'b0);
    send_word(32'sd1, 16'h0001, 1'b1);
    send_word(32'sd42, 16'h0042, 1'b1);        // set of one
    wait_drained();
    write_order(1'b1);
    send_word(32'sd5, 16'h0001, 1'b0);
    send_word(32'sd5, 16'h0002, 1'b0);
    send_word(32'sh7fff_ffff, 16'h0003, 1'b0);
    send_word(-32'sh8000_0000, 16'h0004, 1'b0);
    send_word(32'sd5, 16'h0005, 1'b1);
    wait_drained();
  endtask

  // Store full: words past DEPTH are dropped, last one included
  task automatic test_overflow();
    write_order(1'b0);
    send_run(Depth + 3, -1000, 1000);
    wait_drained();
    send_run(Depth, -5, 5);                     // exactly full, no drop
    wait_drained();
  endtask

  // Output held off for a long stretch while the input keeps offering words
  task automatic test_backpressure();
    hold_out = 1'b1;
    send_run(8, -100, 100);
    send_run(8, -100, 100);
    wait_drained();
  endtask

  task automatic test_random(int unsigned target);
    int unsigned n;
    while (words_in < target) begin
      if (expected_words.size() == 0 && $urandom_range(0, 3) == 0) begin
        wait_drained();
        write_order($urandom_range(0, 1));
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, Depth + 4) : $urandom_range(1, 12);
      if ($urandom_range(0, 1)) send_run(n, -8, 8);
      else send_run(n, -32'sh7fff_ffff - 1, 32'sh7fff_ffff);
    end
    wait_drained();
  endtask

  // Output stall: random bursts, long hold-off on request, none in quiet phase
  initial begin
    int unsigned len;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_out) begin
        out_stall_i <= 1'b1;
        for (int unsigned c = 0; c < 300; c++) @(negedge clk_i);
        hold_out = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        len = $urandom_range(1, 15);
        out_stall_i <= 1'b1;
        repeat (len) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    sorted_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_out++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: key %0d tag %h", sorted_key_o, sorted_tag_o);
      end else begin
        w = expected_words.pop_front();
        if (sorted_key_o !== w.key || sorted_tag_o !== w.tag ||
            end_of_run_o !== w.eor || overflow_o !== w.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected key %0d tag %h eor %0d ovf %0d, got %0d %h %0d %0d",
                     w.key, w.tag, w.eor, w.ovf,
                     sorted_key_o, sorted_tag_o, end_of_run_o, overflow_o);
        end
      end
    end
  end

  // Watchdog
  initial begin
    int unsigned cyc;
    cyc = 0;
    while (cyc < MaxCyc) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("timeout after %0d cycles", cyc);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_overflow();
    test_backpressure();
    test_random(260);
    quiet_phase = 1'b1;
    test_random(290);
    if (expected_words.size() != 0) mismatches++;
    $display("%0d words in, %0d sorted words out over %0d runs", words_in, words_out, runs_closed);
    $display("both orders, overflow, duplicates, extremes and long output hold-off exercised");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
